### hdl/fhcu_pkg.sv
package fhcu_pkg;

  localparam int WIDTH_DEFAULT  = 32;
  localparam int HEIGHT_DEFAULT = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COOLING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARKING = 2'd1;

  // operand of the shared random-scale multiply
  localparam logic [1:0] MUL_LIM  = 2'd0;
  localparam logic [1:0] MUL_ROW  = 2'd1;
  localparam logic [1:0] MUL_HEAT = 2'd2;

  typedef struct packed {
    logic       start;
    logic       draw;
    logic       mul;
    logic [1:0] mul_sel;
    logic       rd;
    logic       addr_spark;
    logic       cool_wr;
    logic       set_spark_row;
    logic       spark_wr;
    logic       mark;
    logic       row_step;
    logic       out_load;
  } fhcu_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic row_last;
    logic spark_hit;
    logic out_free;
  } fhcu_stat_t;

endpackage

### hdl/fire_heat_column_update_core.sv
// Fire heat column update.
// Input channel (in_valid/in_ready, column): one item names a column of the heat
// map. Columns at or beyond WIDTH are taken and dropped with no effect.
// Output channel (out_valid/out_ready): HEIGHT items per column, bottom row first,
// carrying out_column, row, color_index and last (set on the top row).
// Config port (cfg_write/cfg_index/cfg_data): index 0 cooling, index 1 sparking;
// the user is to write it only while no column is in flight; the block itself does not enforce this.
// A column is processed in full before the next is accepted: a cool/drift pass
// reads, cools and drifts each cell in turn, a spark may land, then an output pass
// reads each cell again for the result register.
// The pace is set by the single-port heat memory (each cell is read and
// written in the cool/drift pass, read again for output) and the shared
// random-number/multiply step.
// Reset: the map reads as all zero (a per-column written flag, no clearing
// pass), seed 1337, cooling 55, sparking 120; the block is ready right after.
// A stalled receiver holds the result register; the sequencer waits and the
// input stays closed until the column's last result is loaded.
module fire_heat_column_update_core #(
  parameter int WIDTH  = fhcu_pkg::WIDTH_DEFAULT,
  parameter int HEIGHT = fhcu_pkg::HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fhcu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhcu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [4:0]                      column,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      out_column,
  output logic [3:0]                      row,
  output logic [7:0]                      color_index,
  output logic                            last
);

  fhcu_pkg::fhcu_cmd_t  cmd;
  fhcu_pkg::fhcu_stat_t stat;

  fhcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fhcu_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .column      (column),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_column  (out_column),
    .row         (row),
    .color_index (color_index),
    .last        (last)
  );

endmodule

### hdl/fhcu_ctrl.sv
module fhcu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fhcu_pkg::fhcu_stat_t stat,
  output fhcu_pkg::fhcu_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;
  localparam logic [3:0] S_CMUL  = 4'd2;
  localparam logic [3:0] S_CWR   = 4'd3;
  localparam logic [3:0] S_PDRAW = 4'd4;
  localparam logic [3:0] S_PTEST = 4'd5;
  localparam logic [3:0] S_RDRAW = 4'd6;
  localparam logic [3:0] S_RMUL  = 4'd7;
  localparam logic [3:0] S_ADRAW = 4'd8;
  localparam logic [3:0] S_AMUL  = 4'd9;
  localparam logic [3:0] S_AWR   = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OLD   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // columns outside the map are taken and dropped
        if (in_valid && stat.col_ok) begin
          cmd.start  = 1'b1;
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        cmd.rd     = 1'b1;
        cmd.draw   = 1'b1;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = fhcu_pkg::MUL_LIM;
        state_next  = S_CWR;
      end
      S_CWR: begin
        cmd.cool_wr  = 1'b1;
        cmd.row_step = 1'b1;
        if (stat.row_last) begin
          cmd.mark   = 1'b1;
          state_next = S_PDRAW;
        end else begin
          state_next = S_CRD;
        end
      end
      S_PDRAW: begin
        cmd.draw   = 1'b1;
        state_next = S_PTEST;
      end
      S_PTEST: begin
        state_next = stat.spark_hit ? S_RDRAW : S_ORD;
      end
      S_RDRAW: begin
        cmd.draw   = 1'b1;
        state_next = S_RMUL;
      end
      S_RMUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = fhcu_pkg::MUL_ROW;
        state_next  = S_ADRAW;
      end
      S_ADRAW: begin
        cmd.set_spark_row = 1'b1;
        cmd.draw          = 1'b1;
        state_next        = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul        = 1'b1;
        cmd.mul_sel    = fhcu_pkg::MUL_HEAT;
        cmd.rd         = 1'b1;
        cmd.addr_spark = 1'b1;
        state_next     = S_AWR;
      end
      S_AWR: begin
        cmd.spark_wr   = 1'b1;
        cmd.addr_spark = 1'b1;
        state_next     = S_ORD;
      end
      S_ORD: begin
        cmd.rd     = 1'b1;
        state_next = S_OLD;
      end
      S_OLD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.row_step = 1'b1;
          state_next   = stat.row_last ? S_IDLE : S_ORD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/fhcu_dp.sv
module fhcu_dp #(
  parameter int WIDTH  = fhcu_pkg::WIDTH_DEFAULT,
  parameter int HEIGHT = fhcu_pkg::HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fhcu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fhcu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [4:0]                      column,
  input  fhcu_pkg::fhcu_cmd_t             cmd,
  output fhcu_pkg::fhcu_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      out_column,
  output logic [3:0]                      row,
  output logic [7:0]                      color_index,
  output logic                            last
);

  localparam int XW    = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int YW    = $clog2(HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = HEIGHT << XW;

  localparam logic [15:0] LCG_MUL    = 16'd2053;
  localparam logic [15:0] LCG_INC    = 16'd13849;
  localparam logic [15:0] SEED_RESET = 16'd1337;
  localparam logic [7:0]  COOL_RESET = 8'd55;
  localparam logic [7:0]  SPRK_RESET = 8'd120;
  localparam logic [7:0]  SPARK_ROWS = 8'd7;
  localparam logic [7:0]  SPARK_SPAN = 8'd95;
  localparam logic [7:0]  SPARK_BASE = 8'd160;
  localparam logic [15:0] SCALE_MUL  = 16'd241;

  // cooling*10/HEIGHT by reciprocal, exact while cooling*10*HEIGHT < 2^20
  localparam int          LIM_SHIFT = 20;
  localparam logic [31:0] LIM_MUL   = 32'(10 * ((2 ** LIM_SHIFT + HEIGHT - 1) / HEIGHT));

  function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  // v/3 for v < 768 (8-bit result) via reciprocal 683/2048
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd683;
    return p[18:11];
  endfunction

  logic [7:0]       cooling;
  logic [7:0]       sparking;
  logic [7:0]       lim;
  logic [15:0]      seed;
  logic [15:0]      prod;
  logic [4:0]       col_q;
  logic [YW-1:0]    y;
  logic [2:0]       spark_row;
  logic [7:0]       h1;
  logic [7:0]       h2;
  logic [WIDTH-1:0] touched;
  logic [7:0]       mem [DEPTH];
  logic [7:0]       rdata_raw;

  logic [XW-1:0] xcol;
  logic [7:0]    rnd;
  logic [7:0]    operand;
  logic [7:0]    heat_rd;
  logic [7:0]    cooled;
  logic [9:0]    drift_sum;
  logic [AW-1:0] addr;
  logic          we;
  logic [7:0]    wdata;

  assign xcol    = XW'(col_q);
  assign rnd     = seed[7:0] + seed[15:8];
  // a column never written so far reads as cleared
  assign heat_rd = touched[xcol] ? rdata_raw : 8'd0;
  assign cooled  = sat_sub8(heat_rd, prod[15:8]);
  assign drift_sum = {2'b00, h1} + {1'b0, h2, 1'b0};
  assign addr    = cmd.addr_spark ? {YW'(spark_row), xcol} : {y, xcol};
  assign we      = cmd.cool_wr | cmd.spark_wr;

  always_comb begin
    case (cmd.mul_sel)
      fhcu_pkg::MUL_LIM:  operand = lim;
      fhcu_pkg::MUL_ROW:  operand = SPARK_ROWS;
      fhcu_pkg::MUL_HEAT: operand = SPARK_SPAN;
      default:            operand = lim;
    endcase
  end

  always_comb begin
    if (cmd.spark_wr) begin
      wdata = sat_add8(heat_rd, SPARK_BASE + prod[15:8]);
    end else if (y[YW-1:1] == '0) begin
      wdata = cooled;
    end else begin
      wdata = div3(drift_sum);
    end
  end

  assign stat.col_ok    = int'(column) < WIDTH;
  assign stat.row_last  = (y == YW'(HEIGHT - 1));
  assign stat.spark_hit = (rnd < sparking);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cooling  <= COOL_RESET;
      sparking <= SPRK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fhcu_pkg::REG_COOLING:  cooling  <= cfg_data;
        fhcu_pkg::REG_SPARKING: sparking <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= SEED_RESET;
      y       <= '0;
      touched <= '0;
    end else begin
      if (cmd.draw) begin
        seed <= seed * LCG_MUL + LCG_INC;
      end
      if (cmd.start) begin
        y <= '0;
      end else if (cmd.row_step) begin
        y <= stat.row_last ? '0 : y + YW'(1);
      end
      if (cmd.mark) begin
        touched[xcol] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_q <= column;
      lim   <= 8'((32'(cooling) * LIM_MUL) >> LIM_SHIFT) + 8'd2;
    end
    if (cmd.mul) begin
      prod <= 16'(rnd) * 16'(operand);
    end
    if (cmd.set_spark_row) begin
      spark_row <= prod[10:8];
    end
    if (cmd.cool_wr) begin
      h1 <= cooled;
      h2 <= h1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_raw <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_column  <= col_q;
      row         <= y[3:0];
      color_index <= 8'((16'(heat_rd) * SCALE_MUL) >> 8);
      last        <= stat.row_last;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while occupied");

  a_spark_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.spark_wr |-> touched[xcol])
    else $error("spark written into a column not yet marked");

  a_mark_wraps: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |=> (y == '0))
    else $error("row counter did not wrap after the drift pass");

  a_spark_row: assert property (@(posedge clk) disable iff (rst)
    cmd.spark_wr |-> (spark_row <= 3'd6))
    else $error("spark row outside the bottom seven rows");

endmodule
